// File: hdl/evfo_pkg.sv
package evfo_pkg;

	// Field widths fixed by the interface
	localparam int FREQ_W   = 27;
	localparam int WORK_W   = FREQ_W + 1;
	localparam int STEP_W   = 17;
	localparam int BCD_OUT_W = 32;
	localparam int DCNT_W   = 4;
	localparam int CNT_IN_W = 16;

	// Default parameter values
	localparam int DIGITS_DEF       = 8;
	localparam int COUNTER_BITS_DEF = 16;

	// Decimal digits needed for the widest frequency word
	localparam int MAX_DEC = 9;

	// Reset values
	localparam logic [FREQ_W-1:0] LOW_LIMIT_RST  = 27'd6950000;
	localparam logic [FREQ_W-1:0] HIGH_LIMIT_RST = 27'd7250000;
	localparam logic [FREQ_W-1:0] CARRIER_RST    = 27'd11998800;
	localparam logic [FREQ_W-1:0] FREQ_RST       = 27'd7030000;
	localparam logic [2:0]        STEP_IDX_RST   = 3'd2;
	localparam logic [2:0]        STEP_IDX_LAST  = 3'd5;

	// Register indexes on the configuration port
	localparam logic [1:0] CFG_LOW_LIMIT  = 2'd0;
	localparam logic [1:0] CFG_HIGH_LIMIT = 2'd1;
	localparam logic [1:0] CFG_CARRIER    = 2'd2;

	typedef struct packed {
		logic                req_type;
		logic [CNT_IN_W-1:0] encoder_count;
	} req_t;

	typedef struct packed {
		logic [FREQ_W-1:0]    tuned_freq;
		logic [FREQ_W-1:0]    lo_freq;
		logic [STEP_W-1:0]    step_hz;
		logic [BCD_OUT_W-1:0] freq_bcd;
		logic [DCNT_W-1:0]    digit_count;
	} rsp_t;

	typedef struct packed {
		logic              valid;
		logic [1:0]        index;
		logic [FREQ_W-1:0] data;
	} cfg_wr_t;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DISP,
		OP_LOW,
		OP_INC,
		OP_HIGH,
		OP_INIT,
		OP_STEP,
		OP_PUBLISH
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic is_button;
		logic conv_done;
	} status_t;

	// Tuning step for each step index; unused codes read as 1 Hz
	function automatic logic [STEP_W-1:0] step_of(input logic [2:0] idx);
		logic [STEP_W-1:0] s;
		case (idx)
			3'd0:    s = 17'd1;
			3'd1:    s = 17'd10;
			3'd2:    s = 17'd100;
			3'd3:    s = 17'd1000;
			3'd4:    s = 17'd10000;
			3'd5:    s = 17'd100000;
			default: s = 17'd1;
		endcase
		return s;
	endfunction

	// Powers of ten used for the significant digit count
	function automatic logic [FREQ_W-1:0] pow10(input logic [3:0] k);
		logic [FREQ_W-1:0] p;
		case (k)
			4'd0:    p = 27'd1;
			4'd1:    p = 27'd10;
			4'd2:    p = 27'd100;
			4'd3:    p = 27'd1000;
			4'd4:    p = 27'd10000;
			4'd5:    p = 27'd100000;
			4'd6:    p = 27'd1000000;
			4'd7:    p = 27'd10000000;
			default: p = 27'd100000000;
		endcase
		return p;
	endfunction

endpackage

// File: hdl/evfo_ctrl.sv
module evfo_ctrl
	import evfo_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_stall,
	output logic    rsp_valid,
	input  logic    rsp_stall,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISP,
		S_LOW,
		S_INC,
		S_HIGH,
		S_INIT,
		S_CONV,
		S_PUB
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   slot_free;

	// Result slot is free when empty or being drained this cycle
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Command decode
	always_comb begin
		cmd.op = OP_NONE;
		unique case (state_q)
			S_IDLE: if (req_valid) cmd.op = OP_LOAD;
			S_DISP: cmd.op = OP_DISP;
			S_LOW:  cmd.op = OP_LOW;
			S_INC:  cmd.op = OP_INC;
			S_HIGH: cmd.op = OP_HIGH;
			S_INIT: cmd.op = OP_INIT;
			S_CONV: if (!status.conv_done) cmd.op = OP_STEP;
			S_PUB:  if (slot_free) cmd.op = OP_PUBLISH;
			default: cmd.op = OP_NONE;
		endcase
	end

	// Sequencer and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			// a new result takes the slot, otherwise a drained beat empties it
			if (state_q == S_PUB && slot_free) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (req_valid) state_q <= S_DISP;
				S_DISP: state_q <= status.is_button ? S_INIT : S_LOW;
				S_LOW:  state_q <= S_INC;
				S_INC:  state_q <= S_HIGH;
				S_HIGH: state_q <= S_INIT;
				S_INIT: state_q <= S_CONV;
				S_CONV: if (status.conv_done) state_q <= S_PUB;
				S_PUB:  if (slot_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/evfo_dp.sv
module evfo_dp
	import evfo_pkg::*;
#(
	parameter int DIGITS       = DIGITS_DEF,
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  req_t    req,
	input  cfg_wr_t cfg_wr,
	input  cmd_t    cmd,
	output status_t status,
	output rsp_t    rsp
);

	localparam int PW     = COUNTER_BITS - 2;
	localparam int BCD_W  = 4 * DIGITS;
	localparam int BITCNT_W = $clog2(FREQ_W + 1);

	// Configuration registers
	logic [FREQ_W-1:0] low_q, high_q, carrier_q;

	// Tuning state
	logic [FREQ_W-1:0] freq_q;
	logic [PW-1:0]     last_pos_q;
	logic [2:0]        step_idx_q;

	// Latched event and working value
	logic              type_q;
	logic [PW-1:0]     pos_q;
	logic [WORK_W-1:0] work_q;

	// Conversion registers
	logic [FREQ_W-1:0]   sh_q;
	logic [BCD_W-1:0]    bcd_q;
	logic [BITCNT_W-1:0] bit_cnt_q;
	logic [3:0]          dig_k_q;
	logic [DCNT_W-1:0]   dcount_q;
	logic [FREQ_W-1:0]   lo_q;

	rsp_t rsp_q;

	logic [31:0]          cnt_ext;
	logic [PW-1:0]        pos_in;
	logic [STEP_W-1:0]    step;
	logic [WORK_W-1:0]    step_w, freq_w, low_w, high_w, dec_res, high_res;
	logic [BCD_W-1:0]     bcd_adj;
	logic [BCD_W+BCD_OUT_W-1:0] bcd_ext;

	// Detent position: counter masked to its width, divided by four
	assign cnt_ext = {{(32 - CNT_IN_W){1'b0}}, req.encoder_count};
	assign pos_in  = cnt_ext[COUNTER_BITS-1:2];

	assign step   = step_of(step_idx_q);
	assign step_w = {{(WORK_W - STEP_W){1'b0}}, step};
	assign freq_w = {1'b0, freq_q};
	assign low_w  = {1'b0, low_q};
	assign high_w = {1'b0, high_q};

	// Saturating decrease and high clamp
	assign dec_res  = (freq_w > step_w) ? freq_w - step_w : '0;
	assign high_res = (work_q >= high_w) ? high_w : work_q;

	// Add three to every BCD digit of five or more before the shift
	always_comb begin
		for (int d = 0; d < DIGITS; d++) begin
			if (bcd_q[4*d +: 4] >= 4'd5) bcd_adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
			else bcd_adj[4*d +: 4] = bcd_q[4*d +: 4];
		end
	end

	assign bcd_ext = {{BCD_OUT_W{1'b0}}, bcd_q};

	assign status.is_button = type_q;
	assign status.conv_done = (bit_cnt_q == BITCNT_W'(FREQ_W));
	assign rsp = rsp_q;

	// Configuration and tuning state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q      <= LOW_LIMIT_RST;
			high_q     <= HIGH_LIMIT_RST;
			carrier_q  <= CARRIER_RST;
			freq_q     <= FREQ_RST;
			last_pos_q <= '0;
			step_idx_q <= STEP_IDX_RST;
		end else begin
			if (cfg_wr.valid) begin
				unique case (cfg_wr.index)
					CFG_LOW_LIMIT:  low_q     <= cfg_wr.data;
					CFG_HIGH_LIMIT: high_q    <= cfg_wr.data;
					CFG_CARRIER:    carrier_q <= cfg_wr.data;
					default: ;
				endcase
			end
			if (cmd.op == OP_DISP && type_q) begin
				step_idx_q <= (step_idx_q >= STEP_IDX_LAST) ? 3'd0 : step_idx_q + 3'd1;
			end
			if (cmd.op == OP_HIGH) begin
				freq_q     <= high_res[FREQ_W-1:0];
				last_pos_q <= pos_q;
			end
		end
	end

	// Working registers, conversion and result
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				type_q <= req.req_type;
				pos_q  <= pos_in;
			end
			OP_DISP: work_q <= (last_pos_q > pos_q) ? dec_res : freq_w;
			OP_LOW:  if (work_q <= low_w) work_q <= low_w;
			OP_INC:  if (last_pos_q < pos_q) work_q <= work_q + step_w;
			OP_INIT: begin
				sh_q      <= freq_q;
				bcd_q     <= '0;
				bit_cnt_q <= '0;
				dig_k_q   <= '0;
				dcount_q  <= '0;
				lo_q      <= (carrier_q > freq_q) ? carrier_q - freq_q : '0;
			end
			OP_STEP: begin
				// one binary bit into the BCD register per beat
				bcd_q     <= {bcd_adj[BCD_W-2:0], sh_q[FREQ_W-1]};
				sh_q      <= {sh_q[FREQ_W-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q + 1'b1;
				// one power of ten tested per beat, up to MAX_DEC of them
				if (dig_k_q < 4'(MAX_DEC)) begin
					if (freq_q >= pow10(dig_k_q)) dcount_q <= DCNT_W'(dig_k_q) + 1'b1;
					dig_k_q <= dig_k_q + 4'd1;
				end
			end
			OP_PUBLISH: begin
				rsp_q.tuned_freq  <= freq_q;
				rsp_q.lo_freq     <= lo_q;
				rsp_q.step_hz     <= step;
				rsp_q.freq_bcd    <= bcd_ext[BCD_OUT_W-1:0];
				rsp_q.digit_count <= dcount_q;
			end
			default: ;
		endcase
	end

endmodule

// File: hdl/encoder_tuned_vfo_controller_unit.sv
// VFO tuning controller. Each beat on the request channel is either an encoder
// counter sample (req_type 0), which moves the tuned frequency by one step in
// the direction the detent position moved and clamps it to the configured
// limits, or a step button press (req_type 1), which cycles the step through
// 1, 10, 100, 1k, 10k and 100k Hz. Every request yields exactly one response
// beat carrying the frequency, the local oscillator value, the step, packed
// BCD digits and the significant digit count. An accepted request holds the
// block until its response is published; most of that time is the bit-serial
// binary to BCD conversion, one bit of the 27-bit frequency per cycle. A
// finished response waits in its own register, so the next request may be
// accepted before it is taken. Limits and carrier offset are to be written
// through the configuration port only while idle; the block itself does not
// enforce this, and cfg_ready is always high.
module encoder_tuned_vfo_controller_unit
	import evfo_pkg::*;
#(
	parameter int DIGITS       = DIGITS_DEF,
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [FREQ_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;
	cfg_wr_t cfg_wr;

	// Configuration writes are always taken
	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	evfo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd       (cmd)
	);

	evfo_dp #(
		.DIGITS       (DIGITS),
		.COUNTER_BITS (COUNTER_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cfg_wr (cfg_wr),
		.cmd    (cmd),
		.status (status),
		.rsp    (rsp)
	);

endmodule

// File: tb/tb_encoder_tuned_vfo_controller_unit.sv
module tb_encoder_tuned_vfo_controller_unit
	import evfo_pkg::*;
;

	// Request codes
	localparam logic REQ_ENCODER = 1'b0;
	localparam logic REQ_BUTTON  = 1'b1;

	localparam logic [FREQ_W-1:0] F_MAX = 27'd99999999;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AT_BEAT = 200;
	localparam int PHASES = 14;
	localparam int PHASE_EVENTS = 100;

	typedef enum bit {ROW_EVENT, ROW_BAND} row_kind_t;

	// One line of the directed script: an event, or a new set of limits and offset
	typedef struct {
		row_kind_t         kind;
		req_t              ev;
		bit                known;
		rsp_t              want;
		logic [FREQ_W-1:0] lo_hz;
		logic [FREQ_W-1:0] hi_hz;
		logic [FREQ_W-1:0] offs_hz;
	} script_row_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	req_t              req = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	rsp_t              rsp;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = CFG_LOW_LIMIT;
	logic [FREQ_W-1:0] cfg_data = '0;

	// Tuner state as the block should hold it
	logic [FREQ_W-1:0] freq_now;
	logic [FREQ_W-1:0] lim_low;
	logic [FREQ_W-1:0] lim_high;
	logic [FREQ_W-1:0] carrier_hz;
	logic [13:0]       knob_pos;
	logic [2:0]        step_sel;
	int unsigned       step_ladder [6] = '{1, 10, 100, 1000, 10000, 100000};

	rsp_t        freq_reports_due [$];
	rsp_t        due;
	script_row_t script [$];
	int          mismatches = 0;
	int          events_sent = 0;
	int          quiet = 0;

	encoder_tuned_vfo_controller_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Advance the tuner by one event and return the report it should give
	function automatic rsp_t retune(input req_t ev);
		rsp_t        res;
		int unsigned f;
		int unsigned stp;
		int unsigned v;
		logic [13:0] pos;
		if (ev.req_type == REQ_ENCODER) begin
			pos = ev.encoder_count[15:2];
			stp = step_ladder[step_sel];
			f = freq_now;
			if (pos < knob_pos)
				f = (f > stp) ? f - stp : 0;
			if (f <= lim_low)
				f = lim_low;
			if (pos > knob_pos)
				f = f + stp;
			if (f >= lim_high)
				f = lim_high;
			freq_now = f[FREQ_W-1:0];
			knob_pos = pos;
		end else begin
			step_sel = (step_sel >= 3'd5) ? 3'd0 : step_sel + 3'd1;
		end
		res.tuned_freq = freq_now;
		res.lo_freq = (carrier_hz > freq_now) ? carrier_hz - freq_now : '0;
		res.step_hz = STEP_W'(step_ladder[step_sel]);
		// eight BCD digits, least significant nibble first
		v = freq_now;
		for (int i = 0; i < 8; i++) begin
			res.freq_bcd[4*i +: 4] = 4'(v % 10);
			v = v / 10;
		end
		v = freq_now;
		res.digit_count = '0;
		while (v != 0) begin
			v = v / 10;
			res.digit_count = res.digit_count + 1'b1;
		end
		return res;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
				$time, name, exp_v, exp_v, got_v, got_v);
			mismatches++;
		end
	endtask

	// Offer one event; gaps drawn per beat, with runs of back-to-back beats
	task automatic send_event(input req_t ev, input bit known, input rsp_t want);
		int unsigned gap;
		rsp_t        pred;
		gap = ((events_sent / 40) % 4 == 3) ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= ev;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pred = retune(ev);
		freq_reports_due.push_back(known ? want : pred);
		events_sent++;
	endtask

	// Stop offering and wait for every report to come back
	task automatic settle();
		req_valid <= 1'b0;
		while (freq_reports_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write all three registers back to back; block must be idle
	task automatic set_band(input logic [FREQ_W-1:0] lo_hz, input logic [FREQ_W-1:0] hi_hz,
			input logic [FREQ_W-1:0] offs_hz);
		logic [FREQ_W-1:0] vals [3];
		logic [1:0]        regs [3];
		vals = '{lo_hz, hi_hz, offs_hz};
		regs = '{CFG_LOW_LIMIT, CFG_HIGH_LIMIT, CFG_CARRIER};
		for (int i = 0; i < 3; i++) begin
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
		lim_low = lo_hz;
		lim_high = hi_hz;
		carrier_hz = offs_hz;
	endtask

	// Receiver: random stalls per beat, one long hold-off to back the block up
	initial begin
		int unsigned gap;
		int          beats_taken;
		beats_taken = 0;
		@(posedge arst_n);
		forever begin
			if (beats_taken == HOLD_AT_BEAT)
				gap = HOLD_CYCLES;
			else if ((beats_taken / 32) % 4 == 1)
				gap = 0;
			else
				gap = $urandom_range(0, 14);
			if (gap != 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!(rsp_valid && !rsp_stall))
				@(posedge clk);
			beats_taken++;
		end
	end

	// Response checker
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (freq_reports_due.size() == 0) begin
				$display("%0t: unexpected response beat, expected none, got freq %0d",
					$time, rsp.tuned_freq);
				mismatches++;
			end else begin
				due = freq_reports_due.pop_front();
				check_field("tuned_freq", 32'(due.tuned_freq), 32'(rsp.tuned_freq));
				check_field("lo_freq", 32'(due.lo_freq), 32'(rsp.lo_freq));
				check_field("step_hz", 32'(due.step_hz), 32'(rsp.step_hz));
				check_field("freq_bcd", due.freq_bcd, rsp.freq_bcd);
				check_field("digit_count", 32'(due.digit_count), 32'(rsp.digit_count));
			end
		end
	end

	// Watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	initial begin
		req_t              ev;
		logic [15:0]       knob;
		int unsigned       roll;
		int unsigned       lo_v;
		int unsigned       hi_v;
		int unsigned       offs_v;
		int unsigned       span;

		freq_now = FREQ_RST;
		lim_low = LOW_LIMIT_RST;
		lim_high = HIGH_LIMIT_RST;
		carrier_hz = CARRIER_RST;
		knob_pos = '0;
		step_sel = STEP_IDX_RST;

		// Directed script; typed reports where they follow directly
		script = '{
			'{ROW_EVENT, '{REQ_ENCODER, 16'h0000}, 1'b1,
				'{27'd7030000, 27'd4968800, 17'd100, 32'h07030000, 4'd7}, '0, '0, '0},
			'{ROW_EVENT, '{REQ_ENCODER, 16'hFFFF}, 1'b0, '0, '0, '0, '0},
			'{ROW_EVENT, '{REQ_ENCODER, 16'hFFFC}, 1'b0, '0, '0, '0, '0},
			'{ROW_EVENT, '{REQ_ENCODER, 16'h0003}, 1'b0, '0, '0, '0, '0},
			'{ROW_EVENT, '{REQ_BUTTON, 16'hFFFF}, 1'b0, '0, '0, '0, '0},
			'{ROW_EVENT, '{REQ_BUTTON, 16'h0000}, 1'b0, '0, '0, '0, '0},
			'{ROW_EVENT, '{REQ_BUTTON, 16'h5A5A}, 1'b0, '0, '0, '0, '0},
			'{ROW_EVENT, '{REQ_ENCODER, 16'h0004}, 1'b0, '0, '0, '0, '0},
			'{ROW_EVENT, '{REQ_ENCODER, 16'h0000}, 1'b0, '0, '0, '0, '0},
			'{ROW_EVENT, '{REQ_BUTTON, 16'h0000}, 1'b1,
				'{27'd7030000, 27'd4968800, 17'd1, 32'h07030000, 4'd7}, '0, '0, '0},
			'{ROW_EVENT, '{REQ_BUTTON, 16'h0000}, 1'b0, '0, '0, '0, '0},
			'{ROW_EVENT, '{REQ_BUTTON, 16'h0000}, 1'b0, '0, '0, '0, '0},
			// both limits at zero: the high clamp wins
			'{ROW_BAND, '0, 1'b0, '0, 27'd0, 27'd0, F_MAX},
			'{ROW_EVENT, '{REQ_ENCODER, 16'h5555}, 1'b1,
				'{27'd0, F_MAX, 17'd100, 32'h00000000, 4'd0}, '0, '0, '0},
			// step larger than the frequency: decrease saturates at zero
			'{ROW_BAND, '0, 1'b0, '0, 27'd0, F_MAX, F_MAX},
			'{ROW_EVENT, '{REQ_ENCODER, 16'h0000}, 1'b1,
				'{27'd0, F_MAX, 17'd100, 32'h00000000, 4'd0}, '0, '0, '0},
			// top of range
			'{ROW_BAND, '0, 1'b0, '0, F_MAX, F_MAX, F_MAX},
			'{ROW_EVENT, '{REQ_ENCODER, 16'h0002}, 1'b1,
				'{F_MAX, 27'd0, 17'd100, 32'h99999999, 4'd8}, '0, '0, '0},
			'{ROW_EVENT, '{REQ_ENCODER, 16'hAAAA}, 1'b0, '0, '0, '0, '0},
			// crossed limits: result sits at the high limit
			'{ROW_BAND, '0, 1'b0, '0, 27'd7250000, 27'd6950000, 27'd0},
			'{ROW_EVENT, '{REQ_ENCODER, 16'h1234}, 1'b1,
				'{27'd6950000, 27'd0, 17'd100, 32'h06950000, 4'd7}, '0, '0, '0},
			'{ROW_EVENT, '{REQ_ENCODER, 16'h8001}, 1'b0, '0, '0, '0, '0},
			'{ROW_EVENT, '{REQ_BUTTON, 16'h0000}, 1'b0, '0, '0, '0, '0},
			'{ROW_BAND, '0, 1'b0, '0, LOW_LIMIT_RST, HIGH_LIMIT_RST, CARRIER_RST}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_BAND) begin
				settle();
				set_band(script[i].lo_hz, script[i].hi_hz, script[i].offs_hz);
			end else
				send_event(script[i].ev, script[i].known, script[i].want);
		end
		knob = 16'h8001;

		// Random phases, each under its own limits and offset
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case ($urandom_range(0, 5))
				0: begin
					lo_v = LOW_LIMIT_RST;
					hi_v = HIGH_LIMIT_RST;
				end
				1: begin
					lo_v = 0;
					hi_v = F_MAX;
				end
				2: begin
					span = $urandom_range(0, 400000);
					lo_v = $urandom_range(0, F_MAX);
					hi_v = (lo_v > F_MAX - span) ? F_MAX : lo_v + span;
				end
				3: begin
					span = $urandom_range(1, 500000);
					hi_v = $urandom_range(0, F_MAX - span);
					lo_v = hi_v + span;
				end
				4: begin
					lo_v = $urandom_range(0, F_MAX);
					hi_v = lo_v;
				end
				default: begin
					lo_v = $urandom_range(0, F_MAX);
					hi_v = $urandom_range(0, F_MAX);
				end
			endcase
			if ($urandom_range(0, 2) == 0)
				offs_v = $urandom_range(0, F_MAX);
			else
				offs_v = (lo_v > F_MAX - 200000) ? F_MAX : lo_v + $urandom_range(0, 200000);
			set_band(FREQ_W'(lo_v), FREQ_W'(hi_v), FREQ_W'(offs_v));

			for (int n = 0; n < PHASE_EVENTS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 12)
					ev = '{REQ_BUTTON, 16'($urandom)};
				else if (roll < 20) begin
					knob = 16'($urandom);
					ev = '{REQ_ENCODER, knob};
				end else begin
					// knob turned a few counts either way
					knob = knob + 16'($urandom_range(0, 24)) - 16'd12;
					ev = '{REQ_ENCODER, knob};
				end
				send_event(ev, 1'b0, '0);
			end
		end

		settle();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
